// ===== rtl/mfp_pkg.sv =====
// Shared types and constants for the media frame parser.
// Used by mfp_core, media_frame_parser and mfp_checker; no dependencies.
package mfp_pkg;

    localparam int POS_W = 25;   // frame length never exceeds 38 + 2^24 - 1
    localparam int LEFT_W = 24;

    localparam logic [31:0] HDR_LEN = 32'd38;

    // Byte index of the last byte of each header field
    localparam logic [POS_W-1:0] POS_LEN      = POS_W'(3);
    localparam logic [POS_W-1:0] POS_MAGIC    = POS_W'(7);
    localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_FLAGS    = POS_W'(9);
    localparam logic [POS_W-1:0] POS_STREAM   = POS_W'(13);
    localparam logic [POS_W-1:0] POS_PTS      = POS_W'(21);
    localparam logic [POS_W-1:0] POS_DTS      = POS_W'(29);
    localparam logic [POS_W-1:0] POS_DURATION = POS_W'(33);
    localparam logic [POS_W-1:0] POS_PLEN     = POS_W'(37);

    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_MAXPAY  = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SKIP    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_LONG      = 3'd2,
        ERR_MAGIC     = 3'd3,
        ERR_VERSION   = 3'd4,
        ERR_OVERFLOW  = 3'd5
    } err_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  expected_version;
        logic [23:0] max_payload;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         flags;
        logic signed [31:0] stream_index;
        logic signed [63:0] pts;
        logic signed [63:0] dts;
        logic [31:0]        duration;
        logic [23:0]        payload_len;
        logic [7:0]         payload_byte;
        err_t               error_code;
        logic               last;
    } result_t;

endpackage

// ===== rtl/mfp_core.sv =====
// Byte-serial frame parser state and result decode.
// Depends on mfp_pkg; one byte per accepted beat, at most one result per byte.
module mfp_core
    import mfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_take,
    input  logic [7:0] data_byte,
    input  cfg_t    cfg,
    output logic    res_valid,
    output result_t res
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  frame_total_reg, frame_total_next;
    logic [63:0]       field_shift_reg, field_shift_next;
    logic [LEFT_W-1:0] payload_left_reg, payload_left_next;
    logic [7:0]        held_flags_reg, held_flags_next;
    logic [31:0]       held_stream_reg, held_stream_next;
    logic [63:0]       held_pts_reg, held_pts_next;
    logic [63:0]       held_dts_reg, held_dts_next;
    logic [31:0]       held_duration_reg, held_duration_next;

    logic [63:0]       shifted;
    logic [31:0]       low;
    logic              at_end;
    logic [POS_W-1:0]  room;
    logic [LEFT_W-1:0] left_dec;

    assign shifted  = {field_shift_reg[55:0], data_byte};
    assign low      = shifted[31:0];
    assign at_end   = ({1'b0, pos_reg} + (POS_W+1)'(1)) >= {1'b0, frame_total_reg};
    assign room     = frame_total_reg - POS_W'(HDR_LEN);
    assign left_dec = (payload_left_reg == '0) ? '0 : payload_left_reg - LEFT_W'(1);

    always_comb
    begin
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        frame_total_next   = frame_total_reg;
        field_shift_next   = field_shift_reg;
        payload_left_next  = payload_left_reg;
        held_flags_next    = held_flags_reg;
        held_stream_next   = held_stream_reg;
        held_pts_next      = held_pts_reg;
        held_dts_next      = held_dts_reg;
        held_duration_next = held_duration_reg;
        res_valid          = 1'b0;
        res                = '0;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                res_valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = data_byte;
                payload_left_next = left_dec;
                if (left_dec == '0)
                begin
                    res.last = 1'b1;
                    if (at_end)
                    begin
                        phase_next       = PH_HEADER;
                        pos_next         = '0;
                        field_shift_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        pos_next   = pos_reg + POS_W'(1);
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            PH_SKIP:
            begin
                if (at_end)
                begin
                    phase_next       = PH_HEADER;
                    pos_next         = '0;
                    field_shift_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            default:
            begin
                field_shift_next = shifted;
                pos_next         = pos_reg + POS_W'(1);
                case (pos_reg)
                    POS_LEN:
                    begin
                        frame_total_next = low[POS_W-1:0];
                        if (low < HDR_LEN)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_SHORT;
                        end
                        else if ({1'b0, low} > ({1'b0, HDR_LEN} + {9'b0, cfg.max_payload}))
                        begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_LONG;
                        end
                    end
                    POS_MAGIC:
                    begin
                        if (low != cfg.magic_word)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_MAGIC;
                        end
                    end
                    POS_VERSION:
                    begin
                        if (low[7:0] != cfg.expected_version)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_VERSION;
                        end
                    end
                    POS_FLAGS:    held_flags_next    = low[7:0];
                    POS_STREAM:   held_stream_next   = low;
                    POS_PTS:      held_pts_next      = shifted;
                    POS_DTS:      held_dts_next      = shifted;
                    POS_DURATION: held_duration_next = low;
                    POS_PLEN:
                    begin
                        res_valid = 1'b1;
                        if (low > {{(32-POS_W){1'b0}}, room})
                        begin
                            res.error_code = ERR_OVERFLOW;
                        end
                        else
                        begin
                            payload_left_next = low[LEFT_W-1:0];
                            res.kind          = KIND_HEADER;
                            res.flags         = held_flags_reg;
                            res.stream_index  = held_stream_reg;
                            res.pts           = held_pts_reg;
                            res.dts           = held_dts_reg;
                            res.duration      = held_duration_reg;
                            res.payload_len   = low[23:0];
                            if (low == '0)
                            begin
                                res.last = 1'b1;
                                if (at_end)
                                begin
                                    phase_next       = PH_HEADER;
                                    pos_next         = '0;
                                    field_shift_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    default: ;
                endcase
                // any error resyncs: next byte opens a new length prefix
                if (res.error_code != ERR_NONE)
                begin
                    res.kind         = KIND_ERROR;
                    res.last         = 1'b1;
                    phase_next       = PH_HEADER;
                    pos_next         = '0;
                    field_shift_next = '0;
                end
            end
        endcase

        if (!in_take)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            pos_reg          <= '0;
            frame_total_reg  <= '0;
            field_shift_reg  <= '0;
            payload_left_reg <= '0;
        end
        else if (in_take)
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            frame_total_reg  <= frame_total_next;
            field_shift_reg  <= field_shift_next;
            payload_left_reg <= payload_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            held_flags_reg    <= held_flags_next;
            held_stream_reg   <= held_stream_next;
            held_pts_reg      <= held_pts_next;
            held_dts_reg      <= held_dts_next;
            held_duration_reg <= held_duration_next;
        end
    end

endmodule

// ===== rtl/media_frame_parser.sv =====
// Top level of the media frame parser: APB register file, parser core, output skid stage.
// Depends on mfp_pkg and mfp_core.
//
// Takes one stream byte per cycle on s_t* when s_tready is high and gives at most one
// registered result beat per byte on m_t*. Each byte is decoded by the parser core in a
// single pass; a two-entry output stage (result register plus skid register) lets the input
// keep flowing while m_tready is low until a second result is waiting, so the sustained rate
// is one byte per cycle whenever the result side keeps up. Configuration registers (magic
// at 0x0, version at 0x4, max payload at 0x8) take effect on the next byte.
module media_frame_parser
    import mfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,   // flags, stream_index, pts, dts, duration, payload_len,
                                    // payload_byte, error_code, zero pad
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t    cfg_reg;
    logic    in_take;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    load_out;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word       <= 32'h4D50_4B54;
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.max_payload      <= 24'd1048576;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_MAGIC:   cfg_reg.magic_word       <= pwdata;
                REG_VERSION: cfg_reg.expected_version <= pwdata[7:0];
                REG_MAXPAY:  cfg_reg.max_payload      <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAGIC:   prdata = cfg_reg.magic_word;
            REG_VERSION: prdata = {24'b0, cfg_reg.expected_version};
            REG_MAXPAY:  prdata = {8'b0, cfg_reg.max_payload};
            default:     prdata = '0;
        endcase
    end

    assign s_tready = !skid_valid_reg;
    assign in_take  = s_tvalid && s_tready;

    mfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .data_byte (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign load_out = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'b0, out_reg.error_code, out_reg.payload_byte, out_reg.payload_len,
                       out_reg.duration, out_reg.dts, out_reg.pts, out_reg.stream_index,
                       out_reg.flags};

endmodule

// ===== rtl/mfp_checker.sv =====
// Port-level checks for media_frame_parser, attached by bind.
// Depends on mfp_pkg.
module mfp_checker
    import mfp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [239:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    logic [23:0] plen;
    logic [2:0]  ecode;

    assign plen  = m_tdata[223:200];
    assign ecode = m_tdata[234:232];

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && ecode != ERR_NONE)
        else $error("error beat without last or code");

    a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_HEADER |-> m_tlast == (plen == 24'd0))
        else $error("header last does not match empty payload");

    a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_PAYLOAD |-> ecode == ERR_NONE && plen == 24'd0)
        else $error("payload beat carries header or error fields");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result beat pending");

endmodule

bind media_frame_parser mfp_checker u_mfp_checker (.*);
